FILE: src/quadratic_probe_hash_set_unit_defines.svh
// Assertion macros for the quadratic probe hash set unit.
// Needs clk and rst in scope at the point of use.
`ifndef QUADRATIC_PROBE_HASH_SET_UNIT_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_SET_UNIT_DEFINES_SVH

// Property that must hold at every edge outside reset
`define QPHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Trigger in one cycle implies consequence in the next
`define QPHS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: src/qphs_pkg.sv
// Shared types and codes for the quadratic probe hash set unit.
// No dependencies.
package qphs_pkg;

  // Command codes
  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_ERASE    = 3'd1;
  localparam logic [2:0] CMD_CONTAINS = 3'd2;
  localparam logic [2:0] CMD_CLEAR    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK = 2'd1;
  localparam int unsigned PCT_W = 7;
  localparam logic [PCT_W-1:0] GROW_RESET   = 7'd75;
  localparam logic [PCT_W-1:0] SHRINK_RESET = 7'd25;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [9:0]  slot_index;
  } qphs_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] slot_key;
    logic [10:0] entry_count;
    logic [10:0] slots_in_use;
  } qphs_out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } qphs_status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_HOME_RD, S_HOME_CHK, S_FIND_RD, S_FIND_CHK,
    S_PLACE_RD, S_PLACE_CHK, S_PL_HRD, S_PL_HWR, S_GROW_CHK,
    S_ER_HRD, S_ER_HWR, S_SHR_CHK, S_GATH_RD, S_GATH_CHK,
    S_RH_RD, S_RH_LD, S_RD_RD, S_RD_CHK, S_FIN
  } qphs_state_t;

  // What a clearing sweep returns to
  typedef enum logic [1:0] {
    CLR_RESET, CLR_CMD, CLR_RESIZE
  } qphs_clr_t;

endpackage

FILE: src/qphs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module qphs_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/qphs_core.sv
// Sequencer and table memories of the hash set: probing, placing, erasing,
// clearing sweeps and rehash. Uses qphs_pkg, qphs_ram and the defines header.
`include "quadratic_probe_hash_set_unit_defines.svh"

module qphs_core
  import qphs_pkg::*;
#(
  parameter int unsigned MAX_SLOTS     = 1024,
  parameter int unsigned INITIAL_SLOTS = 16,
  parameter int unsigned KEY_BITS      = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  qphs_in_t         in_item,
  input  logic [PCT_W-1:0] grow_pct,
  input  logic [PCT_W-1:0] shrink_pct,
  input  logic             out_free,
  output qphs_status_t     status,
  output qphs_out_t        result
);

  localparam int unsigned AW       = $clog2(MAX_SLOTS);
  localparam int unsigned CW       = AW + 1;
  localparam int unsigned LW       = $clog2(AW + 1);
  localparam int unsigned KB       = KEY_BITS;
  localparam int unsigned SW       = 1 + 32 + KB;
  localparam int unsigned BW       = 32 + KB;
  localparam int unsigned PW       = CW + PCT_W;
  localparam int unsigned INIT_LOG = $clog2(INITIAL_SLOTS);

  qphs_state_t st, st_next;
  qphs_clr_t   kind;

  logic [2:0]    cmd;
  logic [KB-1:0] key_r;
  logic [31:0]   hash_r;
  logic [9:0]    idx_r;
  logic [CW-1:0] i_cnt;
  logic [AW-1:0] off;
  logic [LW-1:0] cap_log, new_log;
  logic [CW-1:0] key_total;
  logic          ok_r;
  logic [31:0]   skey_r;
  logic [AW-1:0] sweep;
  logic [AW-1:0] pos_r;
  logic [CW-1:0] n_buf, k_cnt;
  logic          rehash;

  // memory ports
  logic          slot_we, home_we, buf_we;
  logic [AW-1:0] slot_waddr, slot_raddr, home_waddr, home_raddr, buf_waddr, buf_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;
  logic [CW-1:0] home_wdata, home_rdata;
  logic [BW-1:0] buf_wdata, buf_rdata;

  logic          done;
  logic [CW-1:0] cap;
  logic [AW-1:0] mask, probe, home_addr;
  logic          s_full, hit, i_last, idx_ok;
  logic [31:0]   s_hash;
  logic [KB-1:0] s_key;
  logic [PW-1:0] load100, grow_lim, shrink_lim;
  logic          grow_go, shrink_go;

  qphs_ram #(.W(SW), .D(MAX_SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  qphs_ram #(.W(CW), .D(MAX_SLOTS)) u_home_ram (
    .clk(clk), .we(home_we), .waddr(home_waddr), .wdata(home_wdata),
    .raddr(home_raddr), .rdata(home_rdata)
  );

  qphs_ram #(.W(BW), .D(MAX_SLOTS)) u_buf_ram (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );

  // capacity, probe address and slot word fields
  assign cap       = CW'(1) << cap_log;
  assign mask      = AW'(cap - CW'(1));
  assign probe     = (hash_r[AW-1:0] + off) & mask;
  assign home_addr = hash_r[AW-1:0] & mask;
  assign s_full    = slot_rdata[SW-1];
  assign s_hash    = slot_rdata[SW-2 -: 32];
  assign s_key     = slot_rdata[KB-1:0];
  assign hit       = s_full && (s_key == key_r);
  assign i_last    = (i_cnt == cap - CW'(1));
  assign idx_ok    = ((32'(in_item.slot_index) >> cap_log) == 32'd0);

  // load thresholds; capacity is a power of two so the product is a shift
  assign load100    = PW'(key_total) * PW'(100);
  assign grow_lim   = PW'(grow_pct) << cap_log;
  assign shrink_lim = PW'(shrink_pct) << cap_log;
  assign grow_go    = (load100 >= grow_lim) && (cap_log < LW'(AW));
  assign shrink_go  = (load100 <= shrink_lim) && (cap_log != '0) &&
                      (key_total <= (cap >> 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
    end else begin
      st <= st_next;
    end
  end

  // next state and memory control
  always_comb begin
    st_next    = st;
    slot_we    = 1'b0;
    slot_waddr = pos_r;
    slot_wdata = '0;
    slot_raddr = probe;
    home_we    = 1'b0;
    home_waddr = home_addr;
    home_wdata = '0;
    home_raddr = home_addr;
    buf_we     = 1'b0;
    buf_waddr  = n_buf[AW-1:0];
    buf_wdata  = {s_hash, s_key};
    buf_raddr  = k_cnt[AW-1:0];
    done       = 1'b0;
    case (st)
      S_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = sweep;
        home_we    = 1'b1;
        home_waddr = sweep;
        if (&sweep) begin
          case (kind)
            CLR_RESET:  st_next = S_IDLE;
            CLR_CMD:    st_next = S_FIN;
            CLR_RESIZE: st_next = (n_buf == '0) ? S_FIN : S_RH_RD;
            default:    st_next = S_IDLE;
          endcase
        end
      end
      S_IDLE: begin
        if (start) begin
          case (in_item.command)
            CMD_INSERT, CMD_ERASE, CMD_CONTAINS: st_next = S_HOME_RD;
            CMD_CLEAR: st_next = S_CLR;
            CMD_READ:  st_next = idx_ok ? S_RD_RD : S_FIN;
            default:   st_next = S_FIN;
          endcase
        end
      end
      S_HOME_RD: st_next = S_HOME_CHK;
      S_HOME_CHK: begin
        if (home_rdata == '0) begin
          st_next = (cmd == CMD_INSERT) ? S_PLACE_RD : S_FIN;
        end else begin
          st_next = S_FIND_RD;
        end
      end
      S_FIND_RD: st_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (hit) begin
          if (cmd == CMD_ERASE) begin
            slot_we    = 1'b1;
            slot_wdata = {1'b0, slot_rdata[SW-2:0]};
            st_next    = S_ER_HRD;
          end else begin
            st_next = S_FIN;
          end
        end else if (i_last) begin
          st_next = (cmd == CMD_INSERT) ? S_PLACE_RD : S_FIN;
        end else begin
          st_next = S_FIND_RD;
        end
      end
      S_PLACE_RD: st_next = S_PLACE_CHK;
      S_PLACE_CHK: begin
        if (!s_full) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b1, hash_r, key_r};
          st_next    = S_PL_HRD;
        end else if (i_last) begin
          st_next = S_FIN;
        end else begin
          st_next = S_PLACE_RD;
        end
      end
      S_PL_HRD: st_next = S_PL_HWR;
      S_PL_HWR: begin
        home_we    = 1'b1;
        home_wdata = CW'(home_rdata + 1'b1);
        if (rehash) begin
          st_next = (k_cnt + CW'(1) == n_buf) ? S_FIN : S_RH_RD;
        end else begin
          st_next = S_GROW_CHK;
        end
      end
      S_GROW_CHK: st_next = grow_go ? S_GATH_RD : S_FIN;
      S_ER_HRD:   st_next = S_ER_HWR;
      S_ER_HWR: begin
        home_we    = 1'b1;
        home_wdata = (home_rdata == '0) ? '0 : CW'(home_rdata - 1'b1);
        st_next    = S_SHR_CHK;
      end
      S_SHR_CHK: st_next = shrink_go ? S_GATH_RD : S_FIN;
      S_GATH_RD: begin
        slot_raddr = sweep;
        st_next    = S_GATH_CHK;
      end
      S_GATH_CHK: begin
        buf_we  = s_full;
        st_next = (sweep == mask) ? S_CLR : S_GATH_RD;
      end
      S_RH_RD: st_next = S_RH_LD;
      S_RH_LD: st_next = S_PLACE_RD;
      S_RD_RD: begin
        slot_raddr = AW'(idx_r);
        st_next    = S_RD_CHK;
      end
      S_RD_CHK: st_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          done    = 1'b1;
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      kind      <= CLR_RESET;
      cap_log   <= LW'(INIT_LOG);
      key_total <= '0;
      rehash    <= 1'b0;
    end else begin
      case (st)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) begin
            key_total <= '0;
            if (kind == CLR_CMD) begin
              ok_r <= 1'b1;
            end
            if (kind == CLR_RESIZE) begin
              cap_log <= new_log;
              k_cnt   <= '0;
              rehash  <= (n_buf != '0);
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd    <= in_item.command;
            key_r  <= KB'(in_item.key);
            hash_r <= in_item.key_hash;
            idx_r  <= in_item.slot_index;
            ok_r   <= 1'b0;
            skey_r <= '0;
            i_cnt  <= '0;
            off    <= '0;
            sweep  <= '0;
            kind   <= CLR_CMD;
          end
        end
        S_FIND_RD, S_PLACE_RD: pos_r <= probe;
        S_FIND_CHK: begin
          if (hit) begin
            ok_r   <= (cmd == CMD_CONTAINS);
            hash_r <= s_hash;
          end else if (i_last) begin
            i_cnt <= '0;
            off   <= '0;
          end else begin
            i_cnt <= i_cnt + 1'b1;
            off   <= off + AW'(i_cnt) + AW'(1);
          end
        end
        S_PLACE_CHK: begin
          if (s_full && !i_last) begin
            i_cnt <= i_cnt + 1'b1;
            off   <= off + AW'(i_cnt) + AW'(1);
          end
        end
        S_PL_HWR: begin
          key_total <= key_total + 1'b1;
          if (rehash) begin
            k_cnt <= k_cnt + 1'b1;
            if (k_cnt + CW'(1) == n_buf) begin
              rehash <= 1'b0;
            end
          end else begin
            ok_r <= 1'b1;
          end
        end
        S_ER_HWR: begin
          key_total <= key_total - 1'b1;
          ok_r      <= 1'b1;
        end
        S_GROW_CHK, S_SHR_CHK: begin
          new_log <= (st == S_GROW_CHK) ? LW'(cap_log + 1'b1) : LW'(cap_log - 1'b1);
          sweep   <= '0;
          n_buf   <= '0;
          kind    <= CLR_RESIZE;
        end
        S_GATH_CHK: begin
          if (s_full) begin
            n_buf <= n_buf + 1'b1;
          end
          sweep <= (sweep == mask) ? '0 : AW'(sweep + 1'b1);
        end
        S_RH_LD: begin
          key_r  <= buf_rdata[KB-1:0];
          hash_r <= buf_rdata[BW-1 -: 32];
          i_cnt  <= '0;
          off    <= '0;
        end
        S_RD_CHK: begin
          ok_r   <= s_full;
          skey_r <= s_full ? 32'(s_key) : 32'd0;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.idle         = (st == S_IDLE);
  assign status.done         = done;
  assign result.ok           = ok_r;
  assign result.slot_key     = skey_r;
  assign result.entry_count  = 11'(key_total);
  assign result.slots_in_use = 11'(cap);

  `QPHS_ASSERT(a_total_fits, key_total <= cap, "key count above capacity")
  `QPHS_ASSERT(a_log_range, cap_log <= LW'(AW), "capacity above maximum")
  `QPHS_ASSERT_NEXT(a_done_idle, status.done, status.idle, "not idle after result")

endmodule

FILE: src/quadratic_probe_hash_set_unit.sv
// Top level of the quadratic probe hash set unit: config registers,
// output register and the core. Uses qphs_pkg and qphs_core.
//
// Usage:
//   in_valid/in_stall/in_data carry one command beat (insert, erase,
//   contains, clear, read slot). out_valid/out_stall/out_data return one
//   result beat per command. cfg_valid/cfg_ready/cfg_index/cfg_data write
//   the grow (index 0) and shrink (index 1) load percentages; cfg_ready is
//   always high.
//   One command is worked on at a time; in_stall is low only when idle.
//   Read slot reads one slot; unknown commands and reads out of range
//   go straight to the result without a table access. A lookup walks the
//   full probe sequence on a miss when the home count is non-zero; clear
//   sweeps every slot. A resize reads every old slot into a buffer, clears
//   every slot and re-places each buffered key, probing on past full slots.
//   Each probe is one access on the slot RAM read port.
//   After reset a clearing pass over every slot runs with in_stall high.
//   The result sits in an output register, so a new command is taken while
//   the receiver stalls; the core holds its next result until that
//   register is free.
module quadratic_probe_hash_set_unit
  import qphs_pkg::*;
#(
  parameter int unsigned MAX_SLOTS     = 1024,
  parameter int unsigned INITIAL_SLOTS = 16,
  parameter int unsigned KEY_BITS      = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qphs_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qphs_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data
);

  logic [PCT_W-1:0] grow_pct, shrink_pct;
  qphs_status_t     status;
  qphs_out_t        result;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = !status.idle;
  assign out_free  = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_pct   <= GROW_RESET;
      shrink_pct <= SHRINK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GROW:   grow_pct   <= cfg_data;
        CFG_SHRINK: shrink_pct <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      out_data <= result;
    end
  end

  qphs_core #(
    .MAX_SLOTS(MAX_SLOTS),
    .INITIAL_SLOTS(INITIAL_SLOTS),
    .KEY_BITS(KEY_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .start(in_valid && !in_stall),
    .in_item(in_data),
    .grow_pct(grow_pct),
    .shrink_pct(shrink_pct),
    .out_free(out_free),
    .status(status),
    .result(result)
  );

endmodule

FILE: tb/tb_quadratic_probe_hash_set_unit.sv
// Self-checking testbench for quadratic_probe_hash_set_unit: directed and random
// command beats, predicted by a behavioural copy of the hash set.
// Depends on qphs_pkg and the quadratic_probe_hash_set_unit RTL.
module tb_quadratic_probe_hash_set_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qphs_pkg::*;

  localparam int unsigned SLOTS_MAX = 1024;
  localparam int unsigned SLOTS_INIT_LOG = 4;
  localparam longint CYCLE_LIMIT = 20000000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  qphs_in_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  qphs_out_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PCT_W-1:0]     cfg_data = '0;

  quadratic_probe_hash_set_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the set
  logic [31:0] sh_key [SLOTS_MAX];
  logic [31:0] sh_hash[SLOTS_MAX];
  bit          sh_full[SLOTS_MAX];
  int unsigned sh_home[SLOTS_MAX];
  int unsigned sh_total = 0;
  int unsigned sh_log = SLOTS_INIT_LOG;
  int unsigned grow_pct = GROW_RESET;
  int unsigned shrink_pct = SHRINK_RESET;

  qphs_in_t  cmd_queue[$];
  qphs_out_t results_due[$];
  int        errors = 0;
  int        send_idle = 0;
  int        recv_stall = 0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  longint    cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned cap_now();
    return 32'd1 << sh_log;
  endfunction

  function automatic int unsigned probe_at(logic [31:0] h, int unsigned i);
    longint unsigned step;
    step = (longint'(i) + longint'(i) * longint'(i)) / 2;
    return int'((longint'(h) + step) & longint'(cap_now() - 1));
  endfunction

  function automatic int locate(logic [31:0] k, logic [31:0] h);
    int unsigned s;
    if (sh_home[h & (cap_now() - 1)] == 0) return -1;
    for (int unsigned i = 0; i < cap_now(); i++) begin
      s = probe_at(h, i);
      if (sh_full[s] && sh_key[s] == k) return int'(s);
    end
    return -1;
  endfunction

  function automatic bit settle(logic [31:0] k, logic [31:0] h);
    int unsigned s;
    for (int unsigned i = 0; i < cap_now(); i++) begin
      s = probe_at(h, i);
      if (!sh_full[s]) begin
        sh_full[s] = 1'b1;
        sh_key[s] = k;
        sh_hash[s] = h;
        sh_home[h & (cap_now() - 1)]++;
        sh_total++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void empty_set();
    for (int s = 0; s < SLOTS_MAX; s++) begin
      sh_full[s] = 1'b0;
      sh_home[s] = 0;
    end
    sh_total = 0;
  endfunction

  // Gather keys in ascending slot order, empty, re-place at the new size
  function automatic void rehash(int unsigned new_log);
    logic [31:0] ks[$];
    logic [31:0] hs[$];
    bit          dummy;
    for (int unsigned s = 0; s < cap_now(); s++)
      if (sh_full[s]) begin
        ks.push_back(sh_key[s]);
        hs.push_back(sh_hash[s]);
      end
    empty_set();
    sh_log = new_log;
    foreach (ks[n]) dummy = settle(ks[n], hs[n]);
  endfunction

  function automatic qphs_out_t predict_result(qphs_in_t c);
    qphs_out_t r;
    int        pos;
    int unsigned home;
    r = '0;
    case (c.command)
      CMD_INSERT: begin
        if (locate(c.key, c.key_hash) < 0 && settle(c.key, c.key_hash)) begin
          r.ok = 1'b1;
          if (longint'(sh_total) * 100 >= longint'(grow_pct) * cap_now() &&
              cap_now() * 2 <= SLOTS_MAX)
            rehash(sh_log + 1);
        end
      end
      CMD_ERASE: begin
        pos = locate(c.key, c.key_hash);
        if (pos >= 0) begin
          home = sh_hash[pos] & (cap_now() - 1);
          sh_full[pos] = 1'b0;
          if (sh_home[home] > 0) sh_home[home]--;
          sh_total--;
          r.ok = 1'b1;
          if (longint'(sh_total) * 100 <= longint'(shrink_pct) * cap_now() &&
              sh_log > 0 && sh_total <= cap_now() / 2)
            rehash(sh_log - 1);
        end
      end
      CMD_CONTAINS: r.ok = locate(c.key, c.key_hash) >= 0;
      CMD_CLEAR: begin
        empty_set();
        r.ok = 1'b1;
      end
      CMD_READ: begin
        if (c.slot_index < cap_now() && sh_full[c.slot_index]) begin
          r.ok = 1'b1;
          r.slot_key = sh_key[c.slot_index];
        end
      end
      default: ;
    endcase
    r.entry_count = sh_total[10:0];
    r.slots_in_use = 11'(cap_now());
    return r;
  endfunction

  // Driver: take accepted beats into the predictor, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(predict_result(in_data));
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_req <= 1'b0;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_stall;
    end
  end

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    qphs_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report("unexpected result", out_data.entry_count, -1);
      end else begin
        want = results_due.pop_front();
        if (out_data.ok !== want.ok) report("ok", out_data.ok, want.ok);
        if (out_data.slot_key !== want.slot_key)
          report("slot_key", out_data.slot_key, want.slot_key);
        if (out_data.entry_count !== want.entry_count)
          report("entry_count", out_data.entry_count, want.entry_count);
        if (out_data.slots_in_use !== want.slots_in_use)
          report("slots_in_use", out_data.slots_in_use, want.slots_in_use);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quadratic_probe_hash_set_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] hash_of(logic [31:0] k);
    return k * 32'h9E37_79B1;
  endfunction

  task automatic queue_cmd(logic [2:0] c, logic [31:0] k, logic [31:0] h,
                           logic [9:0] idx);
    qphs_in_t x;
    x.command = c;
    x.key = k;
    x.key_hash = h;
    x.slot_index = idx;
    cmd_queue.push_back(x);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (cmd_queue.size() > 0 || in_valid || results_due.size() > 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[PCT_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GROW) grow_pct = val;
    else shrink_pct = val;
  endtask

  // Random commands over a small key pool, with some wide keys and stray hashes
  task automatic random_cmds(int n);
    logic [31:0] k;
    logic [31:0] h;
    int unsigned pick;
    logic [2:0]  c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) c = CMD_INSERT;
      else if (pick < 60) c = CMD_ERASE;
      else if (pick < 78) c = CMD_CONTAINS;
      else if (pick < 92) c = CMD_READ;
      else if (pick < 95) c = CMD_CLEAR;
      else c = 3'($urandom_range(5, 7));
      k = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 47);
      h = ($urandom_range(0, 9) == 0) ? $urandom() : hash_of(k);
      queue_cmd(c, k, h, ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 31))
                                                     : 10'($urandom()));
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS_MAX; s++) begin
      sh_full[s] = 1'b0;
      sh_home[s] = 0;
      sh_key[s] = '0;
      sh_hash[s] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, duplicates, misses, unknown codes, clear
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd0);
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd1023);
    queue_cmd(CMD_INSERT, 32'd0, 32'd0, 10'd0);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0);
    queue_cmd(CMD_INSERT, 32'd0, 32'd0, 10'd0);
    queue_cmd(CMD_INSERT, 32'd16, 32'd0, 10'd0);
    queue_cmd(CMD_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0);
    queue_cmd(CMD_CONTAINS, 32'd5, 32'd0, 10'd0);
    queue_cmd(CMD_CONTAINS, 32'd5, 32'd7, 10'd0);
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd0);
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd15);
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd16);
    queue_cmd(CMD_ERASE, 32'd0, 32'd0, 10'd0);
    queue_cmd(CMD_CONTAINS, 32'd16, 32'd0, 10'd0);
    queue_cmd(CMD_ERASE, 32'd77, 32'd0, 10'd0);
    queue_cmd(CMD_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0);
    queue_cmd(3'd5, 32'd1, 32'd1, 10'd1);
    queue_cmd(3'd6, 32'd1, 32'd1, 10'd1);
    queue_cmd(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    queue_cmd(CMD_CLEAR, 32'd0, 32'd0, 10'd0);
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd1);
    drain();

    // Grow to the maximum, then shrink step by step
    write_reg(CFG_GROW, 1);
    write_reg(CFG_SHRINK, 100);
    for (int i = 0; i < 8; i++) queue_cmd(CMD_INSERT, i, hash_of(i), 10'd0);
    queue_cmd(CMD_INSERT, 32'd100, hash_of(32'd100), 10'd0);
    for (int i = 0; i < 9; i++) queue_cmd(CMD_ERASE, i, hash_of(i), 10'd0);
    queue_cmd(CMD_CLEAR, 32'd0, 32'd0, 10'd0);
    drain();

    // Fill every slot at the largest size, then one insert too many
    write_reg(CFG_GROW, 100);
    write_reg(CFG_SHRINK, 0);
    for (int i = 0; i < SLOTS_MAX; i++) queue_cmd(CMD_INSERT, i, i, 10'd0);
    queue_cmd(CMD_INSERT, 32'hDEAD_BEEF, 32'd3, 10'd0);
    queue_cmd(CMD_READ, 32'd0, 32'd0, 10'd1023);
    queue_cmd(CMD_CLEAR, 32'd0, 32'd0, 10'd0);
    drain();

    // Random phases under different back-pressure and thresholds
    write_reg(CFG_GROW, 75);
    write_reg(CFG_SHRINK, 25);
    send_idle = 0;
    recv_stall = 0;
    random_cmds(45);
    hold_req = 1'b1;
    drain();

    write_reg(CFG_GROW, $urandom_range(40, 100));
    write_reg(CFG_SHRINK, $urandom_range(0, 100));
    send_idle = 53;
    recv_stall = 0;
    random_cmds(45);
    drain();

    write_reg(CFG_GROW, 100);
    write_reg(CFG_SHRINK, 100);
    send_idle = 0;
    recv_stall = 53;
    random_cmds(45);
    drain();

    write_reg(CFG_GROW, $urandom_range(40, 100));
    write_reg(CFG_SHRINK, $urandom_range(0, 60));
    send_idle = 12;
    recv_stall = 12;
    random_cmds(45);
    drain();
    repeat (50) @(negedge clk);

    if (errors == 0 && results_due.size() == 0)
      $display("quadratic_probe_hash_set_unit regression: pass");
    else
      $display("quadratic_probe_hash_set_unit regression: fail");
    $finish;
  end

endmodule
